### rtl/core/point_in_polygon_test_defines.svh
// assertion helpers used by the checker file
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PIP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pip_pkg.sv
package pip_pkg;

  localparam int COORD_W      = 14;
  localparam int IDX_W        = 4;
  localparam int CNT_CFG_W    = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 14;
  localparam int MIN_VERTICES = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAY_END_X    = 2'd1;

  localparam logic [COORD_W-1:0] RAY_END_RESET = 14'd10000;

  typedef enum logic {
    REQ_VERTEX = 1'b0,
    REQ_TEST   = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_POS = 2'd1,
    ORI_NEG = 2'd2
  } orient_t;

  // y in the upper half, x in the lower half, as stored in memory
  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic valid;
    logic last;
  } edge_req_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic counted;
    logic on_line;
    logic p_in_box;
  } edge_res_t;

endpackage

### rtl/core/pip_ram.sv
module pip_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/pip_edge.sv
module pip_edge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pip_pkg::edge_req_t                 req,
  input  pip_pkg::point_t                    a,
  input  pip_pkg::point_t                    b,
  input  pip_pkg::point_t                    p,
  input  logic [pip_pkg::COORD_W-1:0]        ray_x,
  output pip_pkg::edge_res_t                 res
);

  localparam int DW     = pip_pkg::COORD_W + 1;
  localparam int PROD_W = 2 * DW;
  localparam int DIFF_W = PROD_W + 1;

  function automatic pip_pkg::orient_t orient_of(input logic signed [DIFF_W-1:0] v);
    if (v == '0) begin
      return pip_pkg::ORI_COL;
    end else if (v[DIFF_W-1]) begin
      return pip_pkg::ORI_NEG;
    end
    return pip_pkg::ORI_POS;
  endfunction

  // orientation of (P, E, R) with E on the row of P: sign of -(ex-px)*(ry-py)
  function automatic pip_pkg::orient_t ray_orient(
    input logic [pip_pkg::COORD_W-1:0] ex,
    input logic [pip_pkg::COORD_W-1:0] px,
    input logic [pip_pkg::COORD_W-1:0] ry,
    input logic [pip_pkg::COORD_W-1:0] py
  );
    if (ex == px || ry == py) begin
      return pip_pkg::ORI_COL;
    end else if ((ex > px) != (ry > py)) begin
      return pip_pkg::ORI_POS;
    end
    return pip_pkg::ORI_NEG;
  endfunction

  function automatic logic in_rng(
    input logic [pip_pkg::COORD_W-1:0] v,
    input logic [pip_pkg::COORD_W-1:0] e0,
    input logic [pip_pkg::COORD_W-1:0] e1
  );
    return (v >= e0 && v <= e1) || (v >= e1 && v <= e0);
  endfunction

  // stage 1: coordinate differences and products
  logic signed [DW-1:0]     dy_ab, dx_ab, dpx_b, dex_b, dpy_b;
  logic signed [PROD_W-1:0] m1_nxt, m2_nxt, m3_nxt;
  logic signed [PROD_W-1:0] m1_r, m2_r, m3_r;
  pip_pkg::point_t          a_r, b_r;
  logic                     v_r, last_r;

  assign dy_ab = $signed({1'b0, b.y}) - $signed({1'b0, a.y});
  assign dx_ab = $signed({1'b0, b.x}) - $signed({1'b0, a.x});
  assign dpx_b = $signed({1'b0, p.x}) - $signed({1'b0, b.x});
  assign dex_b = $signed({1'b0, ray_x}) - $signed({1'b0, b.x});
  assign dpy_b = $signed({1'b0, p.y}) - $signed({1'b0, b.y});

  // the ray end shares P's y, so both edge-side tests share the third product
  assign m1_nxt = dy_ab * dpx_b;
  assign m2_nxt = dy_ab * dex_b;
  assign m3_nxt = dx_ab * dpy_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= req.valid;
    end
    last_r <= req.last;
    m1_r   <= m1_nxt;
    m2_r   <= m2_nxt;
    m3_r   <= m3_nxt;
    a_r    <= a;
    b_r    <= b;
  end

  // stage 2: orientations, boxes and the count decision
  logic signed [DIFF_W-1:0] d1, d2;
  pip_pkg::orient_t         o1, o2, o3, o4;
  logic                     p_box, e_box, a_box, general;

  assign d1 = {m1_r[PROD_W-1], m1_r} - {m3_r[PROD_W-1], m3_r};
  assign d2 = {m2_r[PROD_W-1], m2_r} - {m3_r[PROD_W-1], m3_r};
  assign o1 = orient_of(d1);
  assign o2 = orient_of(d2);
  assign o3 = ray_orient(ray_x, p.x, a_r.y, p.y);
  assign o4 = ray_orient(ray_x, p.x, b_r.y, p.y);

  assign p_box = in_rng(p.x, a_r.x, b_r.x) && in_rng(p.y, a_r.y, b_r.y);
  assign e_box = in_rng(ray_x, a_r.x, b_r.x) && in_rng(p.y, a_r.y, b_r.y);
  assign a_box = in_rng(a_r.x, p.x, ray_x) && (a_r.y == p.y);

  assign general = (o1 != o2) && (o3 != o4) && (o4 != pip_pkg::ORI_COL);

  always_comb begin
    res.valid    = v_r;
    res.last     = last_r;
    res.counted  = general
                || (o1 == pip_pkg::ORI_COL && p_box)
                || (o2 == pip_pkg::ORI_COL && e_box)
                || (o3 == pip_pkg::ORI_COL && a_box);
    // A,P,B collinear is the same test as A,B,P collinear
    res.on_line  = (o1 == pip_pkg::ORI_COL);
    res.p_in_box = p_box;
  end

endmodule

### rtl/core/point_in_polygon_test.sv
// Point-in-polygon test by ray casting. A vertex request writes one polygon
// vertex into the vertex memory without holding off input; writes to a slot at
// or above MAX_VERTICES are dropped. A test request casts a ray from the point
// to (ray_end_x, y) and walks the n = min(vertex_count, MAX_VERTICES) edges, one
// edge per cycle through the single read port of the vertex memory; with fewer
// than three vertices in use it answers outside without reading the memory.
// Requests are held off while a test runs and accepted again once its result
// sits in the output register. Vertices must be written before a test reads
// them.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [pip_pkg::IDX_W-1:0]           in_vertex_index,
  input  logic [pip_pkg::COORD_W-1:0]         in_coord_x,
  input  logic [pip_pkg::COORD_W-1:0]         in_coord_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_inside_res,
  input  logic                                cfg_we,
  input  logic [pip_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pip_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int PW = $bits(pip_pkg::point_t);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [pip_pkg::CNT_CFG_W-1:0] vertex_count_r;
  logic [pip_pkg::COORD_W-1:0]   ray_end_x_r;
  logic [CW-1:0]                 n_r, n_sat, rd_cnt_r;
  logic                          rd_v_r, rd_first_r, rd_last_r;
  pip_pkg::point_t               a_r, p_r, rd_pt;
  logic                          hit_r, hit_val_r, parity_r;
  logic                          out_valid_r, out_inside_res_r;
  logic                          in_acc, test_acc, wr_acc, slot_ok, short_walk, out_free;
  logic [AW-1:0]                 rd_addr;
  logic [PW-1:0]                 rd_data;
  pip_pkg::edge_req_t            edge_req;
  pip_pkg::edge_res_t            edge_res;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign test_acc   = in_acc && (in_req_type == pip_pkg::REQ_TEST);
  assign slot_ok    = 32'(in_vertex_index) < 32'(MAX_VERTICES);
  assign wr_acc     = in_acc && (in_req_type == pip_pkg::REQ_VERTEX) && slot_ok;
  assign n_sat      = (32'(vertex_count_r) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                                 : CW'(vertex_count_r);
  assign short_walk = 32'(n_sat) < 32'(pip_pkg::MIN_VERTICES);
  assign out_free   = !out_valid_r || !out_stall;

  // reads 0 .. n-1 and then vertex 0 again to close the polygon
  assign rd_addr = (rd_cnt_r == n_r) ? '0 : rd_cnt_r[AW-1:0];

  pip_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_acc),
    .waddr (AW'(in_vertex_index)),
    .wdata ({in_coord_y, in_coord_x}),
    .re    (state_r == ST_ISSUE),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_pt = pip_pkg::point_t'(rd_data);

  always_comb begin
    edge_req.valid = rd_v_r && !rd_first_r;
    edge_req.last  = rd_last_r;
  end

  pip_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (edge_req),
    .a     (a_r),
    .b     (rd_pt),
    .p     (p_r),
    .ray_x (ray_end_x_r),
    .res   (edge_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (test_acc) begin
          state_nxt = short_walk ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (rd_cnt_r == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (edge_res.valid && edge_res.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      rd_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      vertex_count_r <= '0;
      ray_end_x_r    <= pip_pkg::RAY_END_RESET;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          pip_pkg::CFG_VERTEX_COUNT: vertex_count_r <= cfg_wdata[pip_pkg::CNT_CFG_W-1:0];
          pip_pkg::CFG_RAY_END_X:    ray_end_x_r    <= cfg_wdata;
          default: ;
        endcase
      end

      rd_v_r <= (state_r == ST_ISSUE);

      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    rd_first_r <= (rd_cnt_r == '0);
    rd_last_r  <= (rd_cnt_r == n_r);
    if (state_r == ST_ISSUE) begin
      rd_cnt_r <= rd_cnt_r + CW'(1);
    end
    if (rd_v_r) begin
      a_r <= rd_pt;
    end

    if (test_acc) begin
      p_r       <= '{y: in_coord_y, x: in_coord_x};
      n_r       <= n_sat;
      rd_cnt_r  <= '0;
      parity_r  <= 1'b0;
      // too few vertices: settle as outside right away
      hit_r     <= short_walk;
      hit_val_r <= 1'b0;
    end else if (edge_res.valid && edge_res.counted && !hit_r) begin
      if (edge_res.on_line) begin
        hit_r     <= 1'b1;
        hit_val_r <= edge_res.p_in_box;
      end else begin
        parity_r <= ~parity_r;
      end
    end

    if (state_r == ST_DONE && out_free) begin
      out_inside_res_r <= hit_r ? hit_val_r : parity_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_res_r;

endmodule

### rtl/core/pip_checker.sv
`include "point_in_polygon_test_defines.svh"

module pip_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_req_type,
  input logic out_valid,
  input logic out_stall,
  input logic out_inside_res
);

  logic in_acc, test_acc, write_acc;

  assign in_acc    = in_valid && !in_stall;
  assign test_acc  = in_acc && (in_req_type == pip_pkg::REQ_TEST);
  assign write_acc = in_acc && (in_req_type == pip_pkg::REQ_VERTEX);

  // a test request holds off input in the cycle after it is accepted
  `PIP_ASSERT_NEXT(a_test_busy, test_acc, in_stall, "test request did not hold off input")

  // a vertex write does not hold off input in the cycle after it
  `PIP_ASSERT_NEXT(a_write_one_cycle, write_acc, !in_stall, "vertex write held off input")

  // a new result only appears while a test holds the input side
  `PIP_ASSERT_SAME(a_result_from_test, $rose(out_valid), $past(in_stall), "result without a test")

  `PIP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_inside_res), "stalled result changed")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

### tb/tb_point_in_polygon_test.sv
import pip_pkg::*;

typedef enum logic [1:0] {
  CHK_OK,
  CHK_UNEXPECTED,
  CHK_WRONG
} check_t;

// keeps its own copy of the vertex memory and registers, predicts each test
class polygon_scoreboard;
  localparam int VERTEX_SLOTS = 16;

  point_t                 vertices [VERTEX_SLOTS];
  logic [CNT_CFG_W-1:0]   vertex_count;
  logic [COORD_W-1:0]     ray_end_x;
  logic                   inside_queue [$];
  int                     tests_seen;
  int                     inside_seen;
  int                     vertex_writes;

  function new();
    foreach (vertices[i]) vertices[i] = '0;
    vertex_count  = '0;
    ray_end_x     = RAY_END_RESET;
    tests_seen    = 0;
    inside_seen   = 0;
    vertex_writes = 0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_VERTEX_COUNT: vertex_count = data[CNT_CFG_W-1:0];
      CFG_RAY_END_X:    ray_end_x = data[COORD_W-1:0];
      default: ;
    endcase
  endfunction

  function orient_t orient(longint px, longint py, longint qx, longint qy,
                           longint rx, longint ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (v == 0) return ORI_COL;
    if (v > 0) return ORI_POS;
    return ORI_NEG;
  endfunction

  // q inside the box spanned by p and r
  function bit in_box(longint px, longint py, longint qx, longint qy,
                      longint rx, longint ry);
    longint xlo, xhi, ylo, yhi;
    xlo = (px < rx) ? px : rx;
    xhi = (px < rx) ? rx : px;
    ylo = (py < ry) ? py : ry;
    yhi = (py < ry) ? ry : py;
    return qx >= xlo && qx <= xhi && qy >= ylo && qy <= yhi;
  endfunction

  function bit edge_crosses(longint ax, longint ay, longint bx, longint by,
                            longint px, longint py, longint ex, longint ey);
    orient_t o1, o2, o3, o4;
    o1 = orient(ax, ay, bx, by, px, py);
    o2 = orient(ax, ay, bx, by, ex, ey);
    o3 = orient(px, py, ex, ey, ax, ay);
    o4 = orient(px, py, ex, ey, bx, by);
    if (o1 != o2 && o3 != o4 && o4 != ORI_COL) return 1'b1;
    if (o1 == ORI_COL && in_box(ax, ay, px, py, bx, by)) return 1'b1;
    if (o2 == ORI_COL && in_box(ax, ay, ex, ey, bx, by)) return 1'b1;
    if (o3 == ORI_COL && in_box(px, py, ax, ay, ex, ey)) return 1'b1;
    return 1'b0;
  endfunction

  function logic point_inside(longint px, longint py);
    int     n;
    int     j;
    int     crossings;
    longint ax, ay, bx, by;
    n = (vertex_count > VERTEX_SLOTS) ? VERTEX_SLOTS : int'(vertex_count);
    if (n < MIN_VERTICES) return 1'b0;
    crossings = 0;
    for (int i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      ax = vertices[i].x;
      ay = vertices[i].y;
      bx = vertices[j].x;
      by = vertices[j].y;
      if (edge_crosses(ax, ay, bx, by, px, py, longint'(ray_end_x), py)) begin
        // point lying on the line of a counted edge decides at once
        if (orient(ax, ay, px, py, bx, by) == ORI_COL)
          return in_box(ax, ay, px, py, bx, by);
        crossings++;
      end
    end
    return crossings[0];
  endfunction

  function void note_request(req_t kind, logic [IDX_W-1:0] slot,
                             logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    logic is_in;
    if (kind == REQ_VERTEX) begin
      if (int'(slot) < VERTEX_SLOTS) vertices[slot] = '{y: y, x: x};
      vertex_writes++;
    end else begin
      is_in = point_inside(longint'(x), longint'(y));
      inside_queue.push_back(is_in);
      tests_seen++;
      if (is_in) inside_seen++;
    end
  endfunction

  function check_t check_result(logic got, output logic want);
    want = 1'bx;
    if (inside_queue.size() == 0) return CHK_UNEXPECTED;
    want = inside_queue.pop_front();
    if (got !== want) return CHK_WRONG;
    return CHK_OK;
  endfunction

  function int pending();
    return inside_queue.size();
  endfunction
endclass

module tb_point_in_polygon_test;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 150;
  localparam int QUIET_LIMIT   = 2000;
  localparam int IDLE_PCT      = 34;
  localparam int PHASES        = 13;

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic                  in_req_type     = REQ_VERTEX;
  logic [IDX_W-1:0]      in_vertex_index = '0;
  logic [COORD_W-1:0]    in_coord_x      = '0;
  logic [COORD_W-1:0]    in_coord_y      = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic                  out_inside_res;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata       = '0;

  logic                  idle_on   = 1'b1;
  int                    hold_seq  = 0;
  int                    hold_seen = 0;
  int                    hold_left = 0;
  int                    mismatches = 0;
  int                    quiet_cycles;
  point_t                poly [16];
  polygon_scoreboard     sb;

  point_in_polygon_test u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_inside_res  (out_inside_res),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  // results are checked before the request of the same edge is noted
  always @(posedge clk) begin
    logic   want;
    check_t status;
    if (rst_n) begin
      if (cfg_we) sb.write_register(cfg_index, cfg_wdata);
      if (out_valid && !out_stall) begin
        status = sb.check_result(out_inside_res, want);
        if (status == CHK_UNEXPECTED)
          report_mismatch("inside_res with no test request pending");
        else if (status == CHK_WRONG)
          report_mismatch($sformatf("inside_res got %b expected %b", out_inside_res, want));
      end
      if (in_valid && !in_stall)
        sb.note_request(req_t'(in_req_type), in_vertex_index, in_coord_x, in_coord_y);
    end
  end

  // result side: random stall, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("FAIL point_in_polygon_test");
    $finish;
  end

  // valid is left high after acceptance; the next call or a drain decides
  task automatic send_req(req_t kind, logic [IDX_W-1:0] slot,
                          logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_vertex_index <= slot;
    in_coord_x      <= x;
    in_coord_y      <= y;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_vertex(logic [IDX_W-1:0] slot, logic [COORD_W-1:0] x,
                            logic [COORD_W-1:0] y);
    poly[slot] = '{y: y, x: x};
    send_req(REQ_VERTEX, slot, x, y);
  endtask

  task automatic test_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    send_req(REQ_TEST, IDX_W'($urandom), x, y);
  endtask

  // valid drops before the wait so the last accepted request is already noted
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] count_word,
                              logic [CFG_DATA_W-1:0] ray, bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VERTEX_COUNT;
    cfg_wdata <= count_word;
    @(posedge clk);
    cfg_index <= CFG_RAY_END_X;
    cfg_wdata <= ray;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // coarse mode puts coordinates on a shared grid so collinear cases show up
  function automatic logic [COORD_W-1:0] pick_coord(bit coarse, int base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (coarse) return COORD_W'(base + 2000 * $urandom_range(0, 6));
    return COORD_W'($urandom_range(0, 16383));
  endfunction

  initial begin
    int                    n_eff;
    int                    n_tests;
    int                    cnt;
    int                    sel;
    int                    k;
    int                    base;
    bit                    coarse;
    logic [CFG_DATA_W-1:0] count_word;
    logic [CFG_DATA_W-1:0] ray;
    logic [COORD_W-1:0]    qx, qy;
    point_t                a, b;

    sb = new();
    foreach (poly[i]) poly[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // fewer than three vertices: always outside
    test_point('0, '0);
    test_point('1, '1);

    // square of side 100, ray to the default end
    put_vertex(4'd0, 14'd100, 14'd100);
    put_vertex(4'd1, 14'd200, 14'd100);
    put_vertex(4'd2, 14'd200, 14'd200);
    put_vertex(4'd3, 14'd100, 14'd200);
    wait_idle();
    program_regs(CFG_DATA_W'(4), CFG_DATA_W'(RAY_END_RESET), 1'b0);
    test_point(14'd150, 14'd150);
    test_point(14'd50, 14'd150);
    test_point(14'd300, 14'd150);
    test_point(14'd150, 14'd100);   // on an edge
    test_point(14'd100, 14'd100);   // on a vertex
    test_point(14'd200, 14'd150);
    test_point(14'd50, 14'd100);    // ray runs along an edge
    test_point(14'd50, 14'd200);
    test_point('0, '0);
    test_point('1, '1);

    // triangle, ray pointing left, junk in the upper count bits and a spare index
    wait_idle();
    program_regs({9'h1a5, 5'd3}, '0, 1'b1);
    test_point(14'd190, 14'd150);
    test_point(14'd120, 14'd150);
    test_point(14'd150, 14'd150);   // on the diagonal
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      sel = $urandom_range(0, 99);
      if (ph == 0) cnt = 16;
      else if (ph == 1) cnt = 31;
      else if (ph == 2) cnt = 3;
      else if (sel < 10) cnt = $urandom_range(0, 2);
      else if (sel < 22) cnt = 16;
      else if (sel < 30) cnt = $urandom_range(17, 31);
      else cnt = $urandom_range(3, 9);
      n_eff  = (cnt > 16) ? 16 : cnt;
      coarse = ($urandom_range(0, 99) < 60);
      base   = $urandom_range(0, 4000);

      count_word = CFG_DATA_W'(cnt);
      if ($urandom_range(0, 3) == 0)
        count_word[CFG_DATA_W-1:CNT_CFG_W] = (CFG_DATA_W - CNT_CFG_W)'($urandom);

      sel = $urandom_range(0, 99);
      if (ph == 0) ray = '0;
      else if (ph == 1) ray = '1;
      else if (sel < 25) ray = RAY_END_RESET;
      else if (sel < 40) ray = '0;
      else if (sel < 55) ray = '1;
      else if (sel < 70) ray = CFG_DATA_W'(base + 2000 * $urandom_range(0, 6));
      else ray = CFG_DATA_W'($urandom_range(0, 16383));

      idle_on <= !(ph == 6 || ph == 7);
      program_regs(count_word, ray, ($urandom_range(0, 4) == 0));

      for (int s = 0; s < n_eff; s++)
        put_vertex(IDX_W'(s), pick_coord(coarse, base), pick_coord(coarse, base));

      if (ph == 4) hold_seq <= hold_seq + 1;

      n_tests = 18 + $urandom_range(0, 6);
      for (int t = 0; t < n_tests; t++) begin
        sel = $urandom_range(0, 99);
        k   = (n_eff == 0) ? 0 : $urandom_range(0, n_eff - 1);
        a   = poly[k];
        b   = poly[(n_eff == 0) ? 0 : (k + 1) % n_eff];
        if (sel < 8) begin
          // rewrite a slot mid-stream
          put_vertex(IDX_W'($urandom_range(0, 15)), pick_coord(coarse, base),
                     pick_coord(coarse, base));
        end else begin
          if (sel < 45 || n_eff == 0) begin
            qx = pick_coord(coarse, base);
            qy = pick_coord(coarse, base);
          end else if (sel < 62) begin
            qx = a.x;
            qy = a.y;
          end else if (sel < 80) begin
            qx = COORD_W'((int'(a.x) + int'(b.x)) / 2);
            qy = COORD_W'((int'(a.y) + int'(b.y)) / 2);
          end else begin
            qx = pick_coord(coarse, base);
            qy = a.y;
          end
          test_point(qx, qy);
        end
      end
      wait_idle();
    end
    idle_on <= 1'b1;

    $display("covered %0d point tests (%0d inside) and %0d vertex writes", sb.tests_seen,
             sb.inside_seen, sb.vertex_writes);
    $display("over %0d polygon settings incl. saturated counts and ray ends at both edges",
             PHASES + 2);
    if (mismatches == 0)
      $display("PASS point_in_polygon_test");
    else
      $display("FAIL point_in_polygon_test");
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/pip_pkg.sv
rtl/core/pip_ram.sv
rtl/core/pip_edge.sv
rtl/core/point_in_polygon_test.sv
rtl/core/pip_checker.sv
tb/tb_point_in_polygon_test.sv
